### rtl/core/rgb_to_hsv_convert_defines.svh
// Assertion macros shared by the division cell and the top level of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RHC_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rgb_to_hsv_convert: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RHC_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rgb_to_hsv_convert: next-cycle check failed");

`endif

### rtl/core/rhc_pkg.sv
// Package with widths, types and constants of the RGB to HSV converter.
package rhc_pkg;

    localparam int COMP_BITS  = 8;
    localparam int ALPHA_W    = 8;
    localparam int HUE_W      = 16;
    localparam int HUE_SECTOR = 3840;
    localparam int HUE_Q_W    = 12;
    localparam int FULL       = (1 << COMP_BITS) - 1;
    localparam int DIV_STEPS  = (COMP_BITS > HUE_Q_W) ? COMP_BITS : HUE_Q_W;
    localparam int P_W        = COMP_BITS + 1;
    localparam int NUM_W      = DIV_STEPS + P_W;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        sector_t                sector;
        logic                   diff_neg;
        logic                   chroma_zero;
        logic [COMP_BITS-1:0]   value;
        logic [ALPHA_W-1:0]     alpha;
    } side_t;

    typedef struct packed {
        logic [P_W-1:0]         hue_p;
        logic [DIV_STEPS-1:0]   hue_q;
        logic [P_W-1:0]         hue_d;
        logic [P_W-1:0]         sat_p;
        logic [DIV_STEPS-1:0]   sat_q;
        logic [P_W-1:0]         sat_d;
        side_t                  side;
    } cell_t;

endpackage

### rtl/core/rhc_front.sv
// Front end: max/min, hue sector and the rounded division operands.
module rhc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rhc_pkg::COMP_BITS-1:0]     red_in,
    input  logic [rhc_pkg::COMP_BITS-1:0]     green_in,
    input  logic [rhc_pkg::COMP_BITS-1:0]     blue_in,
    input  logic [rhc_pkg::ALPHA_W-1:0]       alpha_in,
    output logic                              out_valid,
    output rhc_pkg::cell_t                    out_data,
    input  logic                              out_ready
);

    localparam int C = rhc_pkg::COMP_BITS;

    // Stage one registers.
    logic                   s1_valid_reg;
    logic [C-1:0]           s1_mx_reg;
    logic [C-1:0]           s1_chroma_reg;
    rhc_pkg::sector_t       s1_sector_reg;
    logic [C-1:0]           s1_mag_reg;
    logic                   s1_neg_reg;
    logic [rhc_pkg::ALPHA_W-1:0] s1_alpha_reg;

    // Stage two registers.
    logic                   s2_valid_reg;
    rhc_pkg::cell_t         s2_data_reg;

    logic                   s1_ready;
    logic                   s2_ready;

    logic [C-1:0]           mx;
    logic [C-1:0]           mn;
    rhc_pkg::sector_t       sector;
    logic [C:0]             diff;
    logic [C:0]             mag_full;

    logic [rhc_pkg::NUM_W-1:0] hue_num;
    logic [rhc_pkg::NUM_W-1:0] sat_num;
    rhc_pkg::cell_t         s2_next;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx)
        begin
            mx = green_in;
        end
        if (blue_in > mx)
        begin
            mx = blue_in;
        end
        if (green_in < mn)
        begin
            mn = green_in;
        end
        if (blue_in < mn)
        begin
            mn = blue_in;
        end

        // Red wins a tie for the maximum, then green.
        priority if (mx == red_in)
        begin
            sector = rhc_pkg::SEC_RED;
        end
        else if (mx == green_in)
        begin
            sector = rhc_pkg::SEC_GREEN;
        end
        else
        begin
            sector = rhc_pkg::SEC_BLUE;
        end

        unique case (sector)
            rhc_pkg::SEC_RED:   diff = {1'b0, green_in} - {1'b0, blue_in};
            rhc_pkg::SEC_GREEN: diff = {1'b0, blue_in} - {1'b0, red_in};
            rhc_pkg::SEC_BLUE:  diff = {1'b0, red_in} - {1'b0, green_in};
            default:            diff = '0;
        endcase

        mag_full = diff[C] ? (~diff + 1'b1) : diff;
    end

    always_comb
    begin
        // Rounded quotient of n/d is floor((2n + d) / (2d)).
        hue_num = rhc_pkg::NUM_W'(s1_mag_reg) * rhc_pkg::NUM_W'(2 * rhc_pkg::HUE_SECTOR)
                + rhc_pkg::NUM_W'(s1_chroma_reg);
        sat_num = rhc_pkg::NUM_W'(s1_chroma_reg) * rhc_pkg::NUM_W'(2 * rhc_pkg::FULL)
                + rhc_pkg::NUM_W'(s1_mx_reg);

        s2_next.hue_p = hue_num[rhc_pkg::NUM_W-1 -: rhc_pkg::P_W];
        s2_next.hue_q = hue_num[rhc_pkg::DIV_STEPS-1:0];
        s2_next.hue_d = {s1_chroma_reg, 1'b0};
        s2_next.sat_p = sat_num[rhc_pkg::NUM_W-1 -: rhc_pkg::P_W];
        s2_next.sat_q = sat_num[rhc_pkg::DIV_STEPS-1:0];
        s2_next.sat_d = {s1_mx_reg, 1'b0};
        s2_next.side.sector      = s1_sector_reg;
        s2_next.side.diff_neg    = s1_neg_reg;
        s2_next.side.chroma_zero = (s1_chroma_reg == '0);
        s2_next.side.value       = s1_mx_reg;
        s2_next.side.alpha       = s1_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_mx_reg     <= mx;
            s1_chroma_reg <= mx - mn;
            s1_sector_reg <= sector;
            s1_mag_reg    <= mag_full[C-1:0];
            s1_neg_reg    <= diff[C];
            s1_alpha_reg  <= alpha_in;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_next;
        end
    end

endmodule

### rtl/core/rhc_div_cell.sv
// One restoring-division cell: one quotient bit for the hue and saturation lanes.
`include "rgb_to_hsv_convert_defines.svh"

module rhc_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rhc_pkg::cell_t  in_data,
    output logic            out_valid,
    output rhc_pkg::cell_t  out_data,
    input  logic            out_ready
);

    localparam int PW = rhc_pkg::P_W;
    localparam int QW = rhc_pkg::DIV_STEPS;

    logic            valid_reg;
    rhc_pkg::cell_t  data_reg;
    rhc_pkg::cell_t  data_next;

    logic [PW:0]     hue_t;
    logic [PW:0]     hue_sub;
    logic            hue_ge;
    logic [PW:0]     sat_t;
    logic [PW:0]     sat_sub;
    logic            sat_ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // Shift the next dividend bit into the partial remainder and try a subtract.
        hue_t   = {in_data.hue_p, in_data.hue_q[QW-1]};
        hue_sub = hue_t - {1'b0, in_data.hue_d};
        hue_ge  = (hue_t >= {1'b0, in_data.hue_d});
        sat_t   = {in_data.sat_p, in_data.sat_q[QW-1]};
        sat_sub = sat_t - {1'b0, in_data.sat_d};
        sat_ge  = (sat_t >= {1'b0, in_data.sat_d});

        data_next       = in_data;
        data_next.hue_p = hue_ge ? hue_sub[PW-1:0] : hue_t[PW-1:0];
        data_next.hue_q = {in_data.hue_q[QW-2:0], hue_ge};
        data_next.sat_p = sat_ge ? sat_sub[PW-1:0] : sat_t[PW-1:0];
        data_next.sat_q = {in_data.sat_q[QW-2:0], sat_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    // The partial remainder always stays below a nonzero divisor.
    `RHC_ASSERT_IMP(a_hue_rem_bound, valid_reg && data_reg.hue_d != '0, data_reg.hue_p < data_reg.hue_d)
    `RHC_ASSERT_IMP(a_sat_rem_bound, valid_reg && data_reg.sat_d != '0, data_reg.sat_p < data_reg.sat_d)

endmodule

### rtl/core/rhc_back.sv
// Back end: hue assembly from sector and quotient, special cases, output register.
module rhc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rhc_pkg::cell_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rhc_pkg::HUE_W-1:0]    hue_out,
    output logic [rhc_pkg::COMP_BITS-1:0]       sat_out,
    output logic [rhc_pkg::COMP_BITS-1:0]       value_out,
    output logic [rhc_pkg::ALPHA_W-1:0]         alpha_out
);

    localparam int HW = rhc_pkg::HUE_W;

    logic                               out_valid_reg;
    logic signed [HW-1:0]               hue_reg;
    logic [rhc_pkg::COMP_BITS-1:0]      sat_reg;
    logic [rhc_pkg::COMP_BITS-1:0]      value_reg;
    logic [rhc_pkg::ALPHA_W-1:0]        alpha_reg;

    logic [HW-1:0]                      base;
    logic [HW-1:0]                      frac;
    logic [HW-1:0]                      hue_next;
    logic [rhc_pkg::COMP_BITS-1:0]      sat_next;

    assign in_ready  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign value_out = value_reg;
    assign alpha_out = alpha_reg;

    always_comb
    begin
        unique case (in_data.side.sector)
            rhc_pkg::SEC_RED:   base = '0;
            rhc_pkg::SEC_GREEN: base = HW'(2 * rhc_pkg::HUE_SECTOR);
            rhc_pkg::SEC_BLUE:  base = HW'(4 * rhc_pkg::HUE_SECTOR);
            default:            base = '0;
        endcase

        frac = HW'(in_data.hue_q[rhc_pkg::HUE_Q_W-1:0]);

        // A grey pixel has no defined hue and reads as zero.
        if (in_data.side.chroma_zero)
        begin
            hue_next = '0;
        end
        else
        begin
            hue_next = in_data.side.diff_neg ? (base - frac) : (base + frac);
        end

        if (in_data.side.value == '0)
        begin
            sat_next = '0;
        end
        else
        begin
            sat_next = in_data.sat_q[rhc_pkg::COMP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= in_data.side.value;
            alpha_reg <= in_data.side.alpha;
        end
    end

endmodule

### rtl/core/rgb_to_hsv_convert.sv
// Top level of the RGB to HSV converter: front end, division cell row, back end.
//
// Usage: one pixel per transfer on the input channel (red_in, green_in, blue_in,
// alpha_in with in_valid/in_stall) and one HSV result per transfer on the output
// channel (hue_out, sat_out, value_out, alpha_out with out_valid/out_stall).
// Hue is signed in 1/64 degree units and is not wrapped, so it lies in
// -3840..19200. Saturation is rounded to the nearest step, value is the largest
// component, and alpha is copied through.
// From an input transfer to out_valid a pixel passes two front-end stages,
// one cell per quotient bit in the division row (12 cells), and the output
// register. Throughput is one pixel per cycle while out_stall is low, set by
// the row of division cells, each resolving one quotient bit of both divisions.
// Every stage has its own valid bit and takes new data when it is empty or its
// neighbor takes its contents, so bubbles collapse and the block keeps taking
// pixels while a finished result waits in the output register.
// When the receiver stalls, the result holds and the row fills up; in_stall
// rises only once every stage is occupied. Reset clears all valid bits; the
// block holds no other state and needs no setup.
`include "rgb_to_hsv_convert_defines.svh"

module rgb_to_hsv_convert (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rhc_pkg::COMP_BITS-1:0]       red_in,
    input  logic [rhc_pkg::COMP_BITS-1:0]       green_in,
    input  logic [rhc_pkg::COMP_BITS-1:0]       blue_in,
    input  logic [rhc_pkg::ALPHA_W-1:0]         alpha_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rhc_pkg::HUE_W-1:0]    hue_out,
    output logic [rhc_pkg::COMP_BITS-1:0]       sat_out,
    output logic [rhc_pkg::COMP_BITS-1:0]       value_out,
    output logic [rhc_pkg::ALPHA_W-1:0]         alpha_out
);

    localparam int STEPS = rhc_pkg::DIV_STEPS;

    logic                   front_ready;
    logic [STEPS:0]         chain_valid;
    logic [STEPS:0]         chain_ready;
    rhc_pkg::cell_t         chain_data [STEPS+1];

    assign in_stall = !front_ready;

    // Front end computes max, min, sector and the rounded division operands.
    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_ready (chain_ready[0])
    );

    // Each cell in the row resolves one quotient bit and passes the pixel on.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        rhc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    // Back end forms the final hue, applies the grey and black cases, and
    // holds the result for the receiver.
    rhc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[STEPS]),
        .in_ready  (chain_ready[STEPS]),
        .in_data   (chain_data[STEPS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hue_out   (hue_out),
        .sat_out   (sat_out),
        .value_out (value_out),
        .alpha_out (alpha_out)
    );

    // Hue never leaves its unwrapped range.
    `RHC_ASSERT_IMP(a_hue_range, out_valid, $signed(hue_out) >= -16'sd3840 && $signed(hue_out) <= 16'sd19200)
    // Zero saturation means a grey pixel, which carries zero hue.
    `RHC_ASSERT_IMP(a_grey_hue, out_valid && sat_out == '0, hue_out == '0)
    // A black pixel has neither saturation nor hue.
    `RHC_ASSERT_IMP(a_black_pixel, out_valid && value_out == '0, sat_out == '0 && hue_out == '0)
    // The input side is never held off while the front stage can take data.
    `RHC_ASSERT_NXT(a_no_early_stall, !chain_valid[0] && !$past(in_valid), !in_stall || $past(front_ready))

endmodule
